/* design/dens_pkg.sv */
// dens_pkg: shared types and constants of the directory entry name scanner
// item and result beat structs, command and status codes, store geometry
// no dependencies
`default_nettype none

package dens_pkg;

	localparam int NAME_DEPTH = 255;
	localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

	// block length is BLOCK_BASE shifted left by the clamped size log
	localparam int BLOCK_BASE   = 1024;
	localparam int SIZE_LOG_MAX = 6;
	localparam int HEADER_BYTES = 8;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_BLOCK  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_MATCH    = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_BAD      = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       block_end;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] found_inode;
		logic [15:0] record_offset;
	} result_t;

endpackage

`default_nettype wire

/* design/directory_entry_name_scanner_top.sv */
// directory_entry_name_scanner_top: scans one ext2 directory block for a stored name
// uses dens_pkg for beat types and codes, dens_ram for the wanted name store
//
//  channel  | direction | handshake                | payload
//  item     | in        | item_valid / item_stall     | dens_pkg::item_t
//  result   | out       | result_valid / result_stall | dens_pkg::result_t
//  cfg      | in        | cfg_we                   | cfg_wdata (block_size_log)
//
// one item per cycle while item_stall is low; a block byte is registered into the
// parse stage when taken and parsed there against the name store read launched at
// acceptance, then its result lands in the output register
// append commands with room write the store at acceptance; the name index counter
// runs ahead so the store read always matches the byte entering the parse stage
// reset clears all control state at once; the name store has no clearing pass
// item_stall rises only while a parsed byte waits behind a stalled, full output register
`default_nettype none

module directory_entry_name_scanner_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire dens_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output dens_pkg::result_t     result,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_wdata
);

	import dens_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_SKIP   = 2'd2,
		PH_STOP   = 2'd3
	} phase_t;

	// configuration and name bookkeeping
	logic [2:0]  size_log_q;
	logic [7:0]  wlen_q;
	logic        ovf_q;

	// record parse state
	phase_t      phase_q, phase_d;
	logic        se_q, se_d;
	logic [15:0] bpos_q, bpos_d;
	logic [15:0] estart_q, estart_d;
	logic [15:0] espan_q, espan_d;
	logic [31:0] einode_q, einode_d;
	logic [7:0]  enlen_q, enlen_d;
	logic [7:0]  namek_q, namek_d;

	// parse stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	logic        acc;
	logic        acc_blk;
	logic        s1_go;
	logic        s1_fire;
	logic        have;
	result_t     res_d;
	logic [16:0] blen;
	logic [2:0]  lg;
	logic [7:0]  rd_k;
	logic [7:0]  ram_q;
	logic        name_we;

	assign s1_go      = !result_valid || !result_stall;
	assign s1_fire    = valid_s1 && s1_go;
	assign item_stall = valid_s1 && !s1_go;
	assign acc        = item_valid && !item_stall;
	assign acc_blk    = acc && (item.cmd == CMD_BLOCK);
	assign name_we    = acc && (item.cmd == CMD_APPEND) && ({1'b0, wlen_q} < 9'(NAME_DEPTH));

	assign lg   = (size_log_q > 3'(SIZE_LOG_MAX)) ? 3'(SIZE_LOG_MAX) : size_log_q;
	assign blen = 17'(BLOCK_BASE) << lg;

	// the byte entering the parse stage reads the index the stage will leave behind
	assign rd_k = s1_fire ? namek_d : namek_q;

	dens_ram #(
		.WIDTH(8),
		.DEPTH(NAME_DEPTH)
	) u_name_ram (
		.clk  (clk),
		.we   (name_we),
		.waddr(wlen_q[NAME_AW-1:0]),
		.wdata(item.data_byte),
		.re   (acc_blk),
		.raddr(rd_k[NAME_AW-1:0]),
		.rdata(ram_q)
	);

	always_comb begin
		logic [15:0] rel;
		logic [16:0] rel_p1;
		logic [15:0] span_hi;
		logic [16:0] next_start;
		logic        se_tmp;
		logic        mism;

		rel        = bpos_q - estart_q;
		rel_p1     = {1'b0, rel} + 17'd1;
		span_hi    = {byte_s1, espan_q[7:0]};
		next_start = '0;
		se_tmp     = 1'b0;
		mism       = 1'b0;

		phase_d  = phase_q;
		se_d     = se_q;
		bpos_d   = bpos_q;
		estart_d = estart_q;
		espan_d  = espan_q;
		einode_d = einode_q;
		enlen_d  = enlen_q;
		namek_d  = namek_q;
		have     = 1'b0;
		res_d    = '{status: ST_MATCH, found_inode: '0, record_offset: '0};

		if (s1_fire) begin
			unique case (phase_q)
				PH_HEADER: begin
					priority if (rel == 16'd0) begin
						einode_d = {24'd0, byte_s1};
					end else if (rel < 16'd4) begin
						einode_d = einode_q | ({24'd0, byte_s1} << {rel[1:0], 3'b000});
					end else if (rel == 16'd4) begin
						espan_d = {8'd0, byte_s1};
					end else if (rel == 16'd5) begin
						espan_d = span_hi;
						if (span_hi < 16'(HEADER_BYTES) ||
							({1'b0, estart_q} + {1'b0, span_hi}) > blen) begin
							have  = 1'b1;
							res_d = '{status: ST_BAD, found_inode: '0,
								record_offset: estart_q};
						end
					end else if (rel == 16'd6) begin
						enlen_d = byte_s1;
					end else begin
						namek_d = '0;
						if (einode_q == 32'd0) begin
							phase_d = PH_SKIP;
						end else if ((16'(HEADER_BYTES) + {8'd0, enlen_q}) > espan_q) begin
							have  = 1'b1;
							res_d = '{status: ST_BAD, found_inode: '0,
								record_offset: estart_q};
						end else begin
							se_tmp = (enlen_q == wlen_q) && !ovf_q;
							se_d   = se_tmp;
							if (enlen_q == 8'd0) begin
								if (se_tmp) begin
									have  = 1'b1;
									res_d = '{status: ST_MATCH, found_inode: einode_q,
										record_offset: estart_q};
								end else begin
									phase_d = PH_SKIP;
								end
							end else begin
								phase_d = PH_NAME;
							end
						end
					end
				end
				PH_NAME: begin
					mism    = ({1'b0, namek_q} >= 9'(NAME_DEPTH)) || (ram_q != byte_s1);
					se_d    = se_q && !mism;
					namek_d = namek_q + 8'd1;
					if (({1'b0, namek_q} + 9'd1) >= {1'b0, enlen_q}) begin
						if (se_d) begin
							have  = 1'b1;
							res_d = '{status: ST_MATCH, found_inode: einode_q,
								record_offset: estart_q};
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
				end
				PH_STOP: begin
				end
			endcase

			if (have) begin
				phase_d = PH_STOP;
				se_d    = 1'b1;
			end else if (phase_d == PH_SKIP && rel_p1 >= {1'b0, espan_d}) begin
				next_start = {1'b0, estart_q} + {1'b0, espan_d};
				if (next_start >= blen) begin
					phase_d = PH_STOP;
					se_d    = 1'b0;
				end else begin
					estart_d = next_start[15:0];
					phase_d  = PH_HEADER;
				end
			end

			bpos_d = bpos_q + 16'd1;

			if (end_s1) begin
				// a block that already reported stays silent at its end
				if (!have && !(phase_d == PH_STOP && se_d)) begin
					have = 1'b1;
					if (phase_d == PH_STOP || (phase_d == PH_HEADER && bpos_d == estart_d)) begin
						res_d = '{status: ST_NO_MATCH, found_inode: '0, record_offset: '0};
					end else begin
						res_d = '{status: ST_BAD, found_inode: '0, record_offset: estart_d};
					end
				end
				bpos_d   = '0;
				estart_d = '0;
				espan_d  = '0;
				einode_d = '0;
				enlen_d  = '0;
				phase_d  = PH_HEADER;
				se_d     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log_q   <= '0;
			wlen_q       <= '0;
			ovf_q        <= 1'b0;
			phase_q      <= PH_HEADER;
			se_q         <= 1'b1;
			bpos_q       <= '0;
			estart_q     <= '0;
			espan_q      <= '0;
			einode_q     <= '0;
			enlen_q      <= '0;
			namek_q      <= '0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_log_q <= cfg_wdata;
			end

			if (acc && item.cmd == CMD_CLEAR) begin
				wlen_q <= '0;
				ovf_q  <= 1'b0;
			end else if (acc && item.cmd == CMD_APPEND) begin
				if (name_we) begin
					wlen_q <= wlen_q + 8'd1;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			phase_q  <= phase_d;
			se_q     <= se_d;
			bpos_q   <= bpos_d;
			estart_q <= estart_d;
			espan_q  <= espan_d;
			einode_q <= einode_d;
			enlen_q  <= enlen_d;
			namek_q  <= namek_d;

			if (acc_blk) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire && have) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_blk) begin
			byte_s1 <= item.data_byte;
			end_s1  <= item.block_end;
		end
		if (s1_fire && have) begin
			result <= res_d;
		end
	end

	// a match always names a live record
	a_match_live: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_MATCH |-> result.found_inode != 32'd0)
		else $error("match reported with inode zero");

	// a block that ran out without a match carries no inode and no offset
	a_nomatch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_NO_MATCH |->
			result.found_inode == 32'd0 && result.record_offset == 16'd0)
		else $error("no-match result with nonzero fields");

	// the name index never runs past the record's name
	a_name_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME |-> namek_q < enlen_q)
		else $error("name index beyond record name length");

	// a result is only loaded when the output register is free to take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("pending result lost or changed");

endmodule

`default_nettype wire

/* design/dens_ram.sv */
// dens_ram: generic single-write, single-read memory with registered read data
// read data updates only on a read enable; no reset on the array
// no dependencies
`default_nettype none

module dens_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
